@@ hdl/motor_speed_pi_controller_core_macros.svh @@
// ----------------------------------------------------------------------------
// Motor speed PI controller - assertion macros
// Shared assertion wrappers for the checker files.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_PI_CONTROLLER_CORE_MACROS_SVH
`define MOTOR_SPEED_PI_CONTROLLER_CORE_MACROS_SVH

// Checked only while out of reset.
`define MSP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("msp checker: property failed");

// Checked at every edge, reset included.
`define MSP_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("msp checker: property failed");

`endif

@@ hdl/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor speed PI controller - package
// Widths, register indexes and fixed constants of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

	localparam int RPM_W     = 20;
	localparam int GAIN_W    = 24;
	localparam int DUTY_W    = 20;
	localparam int KTIME_W   = 10;
	localparam int INTEG_W   = 17;
	localparam int EFFORT_W  = 33;
	localparam int OUT_W     = 21;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	localparam int KICK_STEP_MS_DEF = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KICK_DUTY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KICK_TIME  = 3'd5;

	// register reset values
	localparam logic [GAIN_W-1:0]  RST_PROP_GAIN  = 24'd67109;
	localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN = 24'd16777;
	localparam logic [DUTY_W-1:0]  RST_DEADZONE   = 20'd700000;
	localparam logic [DUTY_W-1:0]  RST_MAX_DUTY   = 20'd1000000;
	localparam logic [DUTY_W-1:0]  RST_KICK_DUTY  = 20'd1000000;
	localparam logic [KTIME_W-1:0] RST_KICK_TIME  = 10'd100;

	// 5 rpm in Q8, 0.05 effort in Q32, 1.0 in Q16 and Q32
	localparam logic [RPM_W-1:0]    KICK_SPEED_Q8   = 20'd1280;
	localparam logic [EFFORT_W-1:0] KICK_EFFORT_Q32 = 33'd214748364;
	localparam logic [INTEG_W-1:0]  Q16_ONE         = 17'h10000;
	localparam logic [EFFORT_W-1:0] Q32_ONE         = 33'h1_0000_0000;

endpackage

`default_nettype wire

@@ hdl/msp_sermul.sv @@
// ----------------------------------------------------------------------------
// Motor speed PI controller - serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_sermul #(
	parameter int A_W = 24,
	parameter int B_W = 20
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [A_W-1:0]     mcand,
	input  wire logic [B_W-1:0]     mplier,
	output logic                    done,
	output logic [A_W+B_W-1:0]      prod
);

	localparam int CNT_W = $clog2(B_W + 1);

	logic [A_W-1:0]     mcand_q;
	logic [A_W+B_W-1:0] acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [A_W:0]       sum;

	// upper half accumulates, low half shifts out the multiplier bits
	assign sum = {1'b0, acc_q[A_W+B_W-1:B_W]} + (acc_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(B_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			acc_q   <= {{A_W{1'b0}}, mplier};
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

@@ hdl/motor_speed_pi_controller_core.sv @@
// ----------------------------------------------------------------------------
// Motor speed PI controller - top level
// PI speed loop on magnitudes with start kick and deadzone mapping.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata: target_rpm, measured_rpm; tuser: fresh_measure
//  m_*     | out | m_tvalid/m_tready  | tdata: duty_ns
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
//  An item runs two serial multipliers side by side for the P and I products,
//  then another serial multiplier scales the effort into the duty span. Kick,
//  zero effort and saturated span skip that. A zero target goes straight from
//  idle to the output state. One item is in work at a time; the
//  output register lets the next item enter while a result waits on m_tready.
//  Reset is asynchronous, active low, and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_pi_controller_core
	import msp_pkg::*;
#(
	parameter int KICK_STEP_MS = KICK_STEP_MS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [39:0]          s_tdata,   // [19:0] target_rpm, [39:20] measured_rpm
	input  wire logic [0:0]           s_tuser,   // [0] fresh_measure
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [23:0]               m_tdata,   // [20:0] duty_ns, [23:21] zero
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_START  = 8'b0000_0010,
		S_MUL    = 8'b0000_0100,
		S_INTEG  = 8'b0000_1000,
		S_EFFORT = 8'b0001_0000,
		S_DECIDE = 8'b0010_0000,
		S_SCALE  = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic [GAIN_W-1:0]  prop_gain_q;
	logic [GAIN_W-1:0]  integ_gain_q;
	logic [DUTY_W-1:0]  deadzone_q;
	logic [DUTY_W-1:0]  max_duty_q;
	logic [DUTY_W-1:0]  kick_duty_q;
	logic [KTIME_W-1:0] kick_time_q;

	// controller state
	logic [INTEG_W-1:0] integ_q;
	logic [KTIME_W-1:0] kick_rem_q;
	logic               stopped_q;

	// per item
	logic [RPM_W-1:0]    emag_q;
	logic                eneg_q;
	logic                neg_q;
	logic                mlow_q;
	logic                fresh_q;
	logic [EFFORT_W-1:0] v_q;
	logic [DUTY_W-1:0]   res_q;

	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_duty_q;

	// input decode
	logic             in_acc;
	logic [RPM_W-1:0] tgt_raw;
	logic [RPM_W-1:0] mes_raw;
	logic [RPM_W-1:0] ref_mag;
	logic [RPM_W-1:0] mea_mag;
	logic [RPM_W:0]   err;
	logic [RPM_W-1:0] err_mag;

	assign tgt_raw = s_tdata[19:0];
	assign mes_raw = s_tdata[39:20];
	assign ref_mag = tgt_raw[RPM_W-1] ? (~tgt_raw + RPM_W'(1)) : tgt_raw;
	assign mea_mag = mes_raw[RPM_W-1] ? (~mes_raw + RPM_W'(1)) : mes_raw;
	assign err     = {1'b0, ref_mag} - {1'b0, mea_mag};
	assign err_mag = err[RPM_W] ? RPM_W'(~err + (RPM_W+1)'(1)) : err[RPM_W-1:0];
	assign in_acc  = s_tvalid && s_tready;

	// multipliers
	logic                       mul_start;
	logic                       done_p;
	logic                       done_i;
	logic                       done_d;
	logic                       scale_start;
	logic [GAIN_W+RPM_W-1:0]    prod_p;
	logic [GAIN_W+RPM_W-1:0]    prod_i;
	logic [DUTY_W+EFFORT_W-1:0] prod_d;
	logic [DUTY_W-1:0]          span;

	assign mul_start = (state_q == S_START);
	assign span      = max_duty_q - deadzone_q;

	msp_sermul #(.A_W(GAIN_W), .B_W(RPM_W)) u_mul_p (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (prop_gain_q),
		.mplier (emag_q),
		.done   (done_p),
		.prod   (prod_p)
	);

	msp_sermul #(.A_W(GAIN_W), .B_W(RPM_W)) u_mul_i (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (integ_gain_q),
		.mplier (emag_q),
		.done   (done_i),
		.prod   (prod_i)
	);

	msp_sermul #(.A_W(DUTY_W), .B_W(EFFORT_W)) u_mul_d (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_start),
		.mcand  (span),
		.mplier (v_q),
		.done   (done_d),
		.prod   (prod_d)
	);

	// integrator update, increment truncated toward zero by magnitude
	logic [27:0]        inc;
	logic [28:0]        integ_sum;
	logic [28:0]        integ_dif;
	logic [INTEG_W-1:0] integ_new;

	assign inc       = prod_i[GAIN_W+RPM_W-1:16];
	assign integ_sum = {12'b0, integ_q} + {1'b0, inc};
	assign integ_dif = {12'b0, integ_q} - {1'b0, inc};

	always_comb begin
		if (!fresh_q) begin
			integ_new = integ_q;
		end else if (eneg_q) begin
			integ_new = integ_dif[28] ? '0 : integ_dif[INTEG_W-1:0];
		end else begin
			integ_new = (integ_sum > {12'b0, Q16_ONE}) ? Q16_ONE : integ_sum[INTEG_W-1:0];
		end
	end

	// effort: P plus integrator in Q32, clamped to 0..1
	logic [44:0]         ih;
	logic [44:0]         eff_sum;
	logic [44:0]         eff_dif;
	logic [EFFORT_W-1:0] v_new;

	assign ih      = {12'b0, integ_q, 16'b0};
	assign eff_sum = ih + {1'b0, prod_p};
	assign eff_dif = ih - {1'b0, prod_p};

	always_comb begin
		if (eneg_q) begin
			v_new = eff_dif[44] ? '0 : eff_dif[EFFORT_W-1:0];
		end else begin
			v_new = (eff_sum > {12'b0, Q32_ONE}) ? Q32_ONE : eff_sum[EFFORT_W-1:0];
		end
	end

	// kick and output selection
	logic               kick_fire;
	logic [KTIME_W-1:0] rem_eff;
	logic               kick_on;
	logic               span_neg;

	assign kick_fire   = stopped_q && mlow_q && (v_q > KICK_EFFORT_Q32);
	assign rem_eff     = kick_fire ? kick_time_q : kick_rem_q;
	assign kick_on     = (rem_eff != '0);
	assign span_neg    = (deadzone_q > max_duty_q);
	assign scale_start = (state_q == S_DECIDE) && !kick_on && (v_q != '0) && !span_neg;

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= RST_PROP_GAIN;
			integ_gain_q <= RST_INTEG_GAIN;
			deadzone_q   <= RST_DEADZONE;
			max_duty_q   <= RST_MAX_DUTY;
			kick_duty_q  <= RST_KICK_DUTY;
			kick_time_q  <= RST_KICK_TIME;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN: integ_gain_q <= cfg_data[GAIN_W-1:0];
				REG_DEADZONE:   deadzone_q   <= cfg_data[DUTY_W-1:0];
				REG_MAX_DUTY:   max_duty_q   <= cfg_data[DUTY_W-1:0];
				REG_KICK_DUTY:  kick_duty_q  <= cfg_data[DUTY_W-1:0];
				REG_KICK_TIME:  kick_time_q  <= cfg_data[KTIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			integ_q    <= '0;
			kick_rem_q <= '0;
			stopped_q  <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (ref_mag == '0) begin
							integ_q    <= '0;
							kick_rem_q <= '0;
							stopped_q  <= 1'b1;
							state_q    <= S_OUT;
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_START: state_q <= S_MUL;
				S_MUL: begin
					if (done_p && done_i) begin
						state_q <= S_INTEG;
					end
				end
				S_INTEG: begin
					integ_q <= integ_new;
					state_q <= S_EFFORT;
				end
				S_EFFORT: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (kick_fire || !mlow_q) begin
						stopped_q <= 1'b0;
					end
					if (kick_on) begin
						kick_rem_q <= (rem_eff > KTIME_W'(KICK_STEP_MS))
							? rem_eff - KTIME_W'(KICK_STEP_MS) : '0;
						state_q <= S_OUT;
					end else if (scale_start) begin
						state_q <= S_SCALE;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_SCALE: begin
					if (done_d) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			emag_q  <= err_mag;
			eneg_q  <= err[RPM_W];
			neg_q   <= tgt_raw[RPM_W-1];
			mlow_q  <= (mea_mag < KICK_SPEED_Q8);
			fresh_q <= s_tuser[0];
			res_q   <= '0;
		end
		if (state_q == S_EFFORT) begin
			v_q <= v_new;
		end
		if (state_q == S_DECIDE) begin
			if (kick_on) begin
				res_q <= kick_duty_q;
			end else if (v_q == '0) begin
				res_q <= '0;
			end else if (span_neg) begin
				res_q <= max_duty_q;
			end
		end
		// span not negative here, so the sum stays at or below max_duty
		if (state_q == S_SCALE && done_d) begin
			res_q <= deadzone_q + prod_d[DUTY_W+31:32];
		end
		if (state_q == S_OUT && out_free) begin
			m_duty_q <= neg_q ? (~{1'b0, res_q} + OUT_W'(1)) : {1'b0, res_q};
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, m_duty_q};

endmodule

`default_nettype wire

@@ hdl/msp_checker.sv @@
// ----------------------------------------------------------------------------
// Motor speed PI controller - port checker
// Watches the top level ports; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "motor_speed_pi_controller_core_macros.svh"

module msp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [39:0] s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);

	// zero target taken while the output is empty
	logic zero_in;
	assign zero_in = s_tvalid && s_tready && (s_tdata[19:0] == 20'd0) && !m_tvalid;

	`MSP_ASSERT_ALWAYS(a_no_valid_in_reset, clk, (!arst_n |=> !m_tvalid))

	`MSP_ASSERT(a_out_hold, clk, arst_n, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)))

	// one item in work: the input closes right after an accept
	`MSP_ASSERT(a_one_in_work, clk, arst_n, (s_tvalid && s_tready |=> !s_tready))

	// zero target passes through the output state and gives a zero duty when the output is free
	`MSP_ASSERT(a_zero_target, clk, arst_n, (zero_in |=> ##1 (m_tvalid && m_tdata == 24'd0)))

endmodule

bind motor_speed_pi_controller_core msp_checker u_msp_checker (.*);

`default_nettype wire
